/* sv/ihex_pkg.sv */
// ----------------------------------------------------------------------------
// ihex_pkg
// types, constants and the hex digit decode shared by the record parser
// ----------------------------------------------------------------------------
`default_nettype none

package ihex_pkg;

	localparam logic [7:0] CHAR_COLON = 8'h3A;
	localparam logic [7:0] CHAR_SEMI  = 8'h3B;

	localparam logic [9:0] POS_COUNT   = 10'd2;
	localparam logic [9:0] POS_ADDR_HI = 10'd4;
	localparam logic [9:0] POS_ADDR_LO = 10'd6;
	localparam logic [9:0] POS_TYPE    = 10'd8;
	localparam logic [9:0] POS_MAX     = 10'd1023;
	localparam logic [9:0] POS_WRAP    = 10'd1022;

	localparam logic [8:0] SEEN_MAX  = 9'd511;
	localparam logic [8:0] COUNT_SAT = 9'd255;

	typedef enum logic [1:0] {
		CLASS_DATA    = 2'd0,
		CLASS_INVALID = 2'd1,
		CLASS_COMMENT = 2'd2,
		CLASS_UNKNOWN = 2'd3
	} line_class_t;

	typedef enum logic {
		KIND_BYTE   = 1'b0,
		KIND_STATUS = 1'b1
	} result_kind_t;

	typedef struct packed {
		result_kind_t result_kind;
		logic [7:0]   data_byte;
		logic [15:0]  byte_address;
		logic [7:0]   record_kind;
		line_class_t  line_class;
		logic [7:0]   data_count;
		logic         sum_ok;
		logic         run_last;
	} ihex_result_t;

	// results of one character, first slot filled before second
	typedef struct packed {
		logic [1:0]   count;
		ihex_result_t first;
		ihex_result_t second;
	} ihex_push_t;

	typedef struct packed {
		logic       ok;
		logic [3:0] value;
	} hex_digit_t;

	function automatic hex_digit_t hex_decode(input logic [7:0] c);
		hex_digit_t d;
		logic [7:0] t;
		d.ok = 1'b0;
		d.value = 4'd0;
		t = 8'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			t = c - 8'h30;
			d.ok = 1'b1;
			d.value = t[3:0];
		end else if (c >= 8'h41 && c <= 8'h46) begin
			t = c - 8'h37;
			d.ok = 1'b1;
			d.value = t[3:0];
		end else if (c >= 8'h61 && c <= 8'h66) begin
			t = c - 8'h57;
			d.ok = 1'b1;
			d.value = t[3:0];
		end
		return d;
	endfunction

	function automatic logic [7:0] sat_count(input logic [8:0] n);
		return (n > COUNT_SAT) ? 8'hFF : n[7:0];
	endfunction

endpackage

`default_nettype wire

/* sv/ihex_parse.sv */
// ----------------------------------------------------------------------------
// ihex_parse
// per-line record state and the combinational character decode
// ----------------------------------------------------------------------------
`default_nettype none

module ihex_parse
	import ihex_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       accept,
	input  wire logic [7:0] char_code,
	input  wire logic       line_end,
	input  wire logic       check_sum_enable,
	output ihex_push_t      push
);

	logic [9:0]  pos_q, pos_d;
	logic [3:0]  nib_q, nib_d;
	logic [7:0]  decl_q, decl_d;
	logic [15:0] addr_q, addr_d;
	logic [7:0]  type_q, type_d;
	logic [7:0]  pend_q, pend_d;
	logic        pend_v_q, pend_v_d;
	logic [8:0]  seen_q, seen_d;
	logic [7:0]  sum_q, sum_d;
	line_class_t class_q, class_d;
	logic        err_q, err_d;

	hex_digit_t   hd;
	logic [7:0]   b;
	logic         emit;
	ihex_result_t res_byte;
	ihex_result_t res_stat;
	logic         whole;
	logic         ok;
	line_class_t  cls;

	assign hd = hex_decode(char_code);
	assign b  = {nib_q, hd.value};

	// next state of the record
	always_comb begin
		pos_d    = (pos_q < POS_MAX) ? pos_q + 10'd1 : POS_WRAP;
		nib_d    = nib_q;
		decl_d   = decl_q;
		addr_d   = addr_q;
		type_d   = type_q;
		pend_d   = pend_q;
		pend_v_d = pend_v_q;
		seen_d   = seen_q;
		sum_d    = sum_q;
		class_d  = class_q;
		err_d    = err_q;
		emit     = 1'b0;
		if (pos_q == 10'd0) begin
			if (char_code == CHAR_COLON)
				class_d = CLASS_DATA;
			else if (char_code == CHAR_SEMI)
				class_d = CLASS_COMMENT;
			else
				class_d = CLASS_UNKNOWN;
		end else if (class_q == CLASS_DATA && !err_q) begin
			if (!hd.ok) begin
				err_d = 1'b1;
			end else if (pos_q[0]) begin
				nib_d = hd.value;
			end else begin
				sum_d = sum_q + b;
				if (pos_q == POS_COUNT) begin
					decl_d = b;
				end else if (pos_q == POS_ADDR_HI) begin
					addr_d = {b, addr_q[7:0]};
				end else if (pos_q == POS_ADDR_LO) begin
					addr_d = {addr_q[15:8], b};
				end else if (pos_q == POS_TYPE) begin
					type_d = b;
				end else begin
					if (pend_v_q) begin
						emit = 1'b1;
						if (seen_q < SEEN_MAX)
							seen_d = seen_q + 9'd1;
					end
					pend_d   = b;
					pend_v_d = 1'b1;
				end
			end
		end
	end

	// results of this character
	always_comb begin
		whole = (pos_q != 10'd0) && !pos_q[0] && pend_v_d && !err_d;
		ok    = 1'b0;
		cls   = class_d;
		if (class_d == CLASS_DATA) begin
			ok = whole && (sum_d == 8'd0);
			if (!whole || seen_d != {1'b0, decl_d} || (check_sum_enable && !ok))
				cls = CLASS_INVALID;
		end

		res_byte.result_kind  = KIND_BYTE;
		res_byte.data_byte    = pend_q;
		res_byte.byte_address = addr_q + {7'd0, seen_q};
		res_byte.record_kind  = type_q;
		res_byte.line_class   = CLASS_DATA;
		res_byte.data_count   = sat_count(seen_d);
		res_byte.sum_ok       = 1'b0;
		res_byte.run_last     = !line_end;

		res_stat.result_kind  = KIND_STATUS;
		res_stat.line_class   = cls;
		res_stat.sum_ok       = ok;
		res_stat.run_last     = 1'b1;
		if (class_d == CLASS_DATA) begin
			res_stat.data_byte    = pend_d;
			res_stat.byte_address = addr_d;
			res_stat.record_kind  = type_d;
			res_stat.data_count   = sat_count(seen_d);
		end else begin
			res_stat.data_byte    = 8'd0;
			res_stat.byte_address = 16'd0;
			res_stat.record_kind  = 8'd0;
			res_stat.data_count   = 8'd0;
		end

		push.count  = 2'd0;
		push.first  = res_byte;
		push.second = res_stat;
		if (accept) begin
			if (emit)
				push.count = line_end ? 2'd2 : 2'd1;
			else if (line_end) begin
				push.count = 2'd1;
				push.first = res_stat;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			nib_q    <= '0;
			decl_q   <= '0;
			addr_q   <= '0;
			type_q   <= '0;
			pend_q   <= '0;
			pend_v_q <= 1'b0;
			seen_q   <= '0;
			sum_q    <= '0;
			class_q  <= CLASS_DATA;
			err_q    <= 1'b0;
		end else if (accept) begin
			if (line_end) begin
				pos_q    <= '0;
				nib_q    <= '0;
				decl_q   <= '0;
				addr_q   <= '0;
				type_q   <= '0;
				pend_q   <= '0;
				pend_v_q <= 1'b0;
				seen_q   <= '0;
				sum_q    <= '0;
				class_q  <= CLASS_DATA;
				err_q    <= 1'b0;
			end else begin
				pos_q    <= pos_d;
				nib_q    <= nib_d;
				decl_q   <= decl_d;
				addr_q   <= addr_d;
				type_q   <= type_d;
				pend_q   <= pend_d;
				pend_v_q <= pend_v_d;
				seen_q   <= seen_d;
				sum_q    <= sum_d;
				class_q  <= class_d;
				err_q    <= err_d;
			end
		end
	end

endmodule

`default_nettype wire

/* sv/ihex_out_queue.sv */
// ----------------------------------------------------------------------------
// ihex_out_queue
// result queue taking up to two results per cycle, one out per transfer
// ----------------------------------------------------------------------------
`default_nettype none

module ihex_out_queue
	import ihex_pkg::*;
#(
	parameter int DEPTH = 4
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire ihex_push_t push,
	output logic        room,
	output logic        out_valid,
	input  wire logic   out_stall,
	output ihex_result_t head
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	ihex_result_t   mem [2**AW];
	logic [AW-1:0]  wr_ptr_q;
	logic [AW-1:0]  rd_ptr_q;
	logic [CW-1:0]  count_q;
	logic           pop;

	assign out_valid = count_q != '0;
	assign pop       = out_valid && !out_stall;
	assign room      = count_q <= CW'(DEPTH - 2);
	assign head      = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push.count != 2'd0)
			mem[wr_ptr_q] <= push.first;
		if (push.count == 2'd2)
			mem[wr_ptr_q + AW'(1)] <= push.second;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + AW'(push.count);
			if (pop)
				rd_ptr_q <= rd_ptr_q + AW'(1);
			count_q <= count_q + CW'(push.count) - CW'(pop);
		end
	end

endmodule

`default_nettype wire

/* sv/intel_hex_record_parser_unit.sv */
// results are registered in the result queue before they can be taken
// throughput: one character per cycle unless in_stall; a character yields up
// to two results, which leave one per cycle through the result queue unless
// out_stall; input stalls while the queue has fewer than two free places
// reset: asynchronous, clears line state, queue and check_sum_enable
// ----------------------------------------------------------------------------
// intel_hex_record_parser_unit
// streaming record parser: line classing, byte decode, checksum status
// ----------------------------------------------------------------------------
`default_nettype none

module intel_hex_record_parser_unit
	import ihex_pkg::*;
#(
	parameter int QUEUE_DEPTH = 4
) (
	input  wire logic        clk,
	input  wire logic        arst_n,

	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic        check_sum_enable,

	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  char_code,
	input  wire logic        line_end,

	output logic             out_valid,
	input  wire logic        out_stall,
	output logic             result_kind,
	output logic [7:0]       data_byte,
	output logic [15:0]      byte_address,
	output logic [7:0]       record_kind,
	output logic [1:0]       line_class,
	output logic [7:0]       data_count,
	output logic             sum_ok,
	output logic             run_last
);

	logic         check_sum_enable_q;
	logic         room;
	logic         accept;
	ihex_push_t   push;
	ihex_result_t head;

	assign cfg_ready = 1'b1;
	assign in_stall  = !room;
	assign accept    = in_valid && room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			check_sum_enable_q <= 1'b0;
		else if (cfg_valid)
			check_sum_enable_q <= check_sum_enable;
	end

	ihex_parse u_parse (
		.clk              (clk),
		.arst_n           (arst_n),
		.accept           (accept),
		.char_code        (char_code),
		.line_end         (line_end),
		.check_sum_enable (check_sum_enable_q),
		.push             (push)
	);

	ihex_out_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.room      (room),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.head      (head)
	);

	assign result_kind  = head.result_kind;
	assign data_byte    = head.data_byte;
	assign byte_address = head.byte_address;
	assign record_kind  = head.record_kind;
	assign line_class   = head.line_class;
	assign data_count   = head.data_count;
	assign sum_ok       = head.sum_ok;
	assign run_last     = head.run_last;

endmodule

`default_nettype wire
